FILE: rtl/reversible_indexed_deque_core_macros.svh
// Assertion macros shared by the deque core files.
`ifndef REVERSIBLE_INDEXED_DEQUE_CORE_MACROS_SVH
`define REVERSIBLE_INDEXED_DEQUE_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define RID_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define RID_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/rid_pkg.sv
// Types and constants for the reversible indexed deque.
package rid_pkg;

  localparam int OPC_W   = 4;
  localparam int POS_W   = 10;
  localparam int VAL_W   = 64;
  localparam int CNT_O_W = 11;
  localparam int TDATA_W = 80;

  localparam logic [OPC_W-1:0] OP_PUSH_L = 4'd0;
  localparam logic [OPC_W-1:0] OP_PUSH_R = 4'd1;
  localparam logic [OPC_W-1:0] OP_POP_L  = 4'd2;
  localparam logic [OPC_W-1:0] OP_POP_R  = 4'd3;
  localparam logic [OPC_W-1:0] OP_GET    = 4'd4;
  localparam logic [OPC_W-1:0] OP_SET    = 4'd5;
  localparam logic [OPC_W-1:0] OP_PEEK_L = 4'd6;
  localparam logic [OPC_W-1:0] OP_PEEK_R = 4'd7;
  localparam logic [OPC_W-1:0] OP_REV    = 4'd8;

  // result word, value in the low bits
  typedef struct packed {
    logic                 is_full;
    logic                 is_empty;
    logic [CNT_O_W-1:0]   count;
    logic                 ok;
    logic [VAL_W-1:0]     value_out;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/rid_ram.sv
// Generic single-port RAM with registered read.
module rid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/reversible_indexed_deque_core.sv
// Top level: ring-buffer deque with reverse flag and indexed access.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   in_      | in  | in_tvalid/tready   | in_tdata: opcode, position, value_in
//   out_     | out | out_tvalid/tready  | out_tdata: value_out, ok, count,
//            |     |                    |   is_empty, is_full
//
// Push, pop, set, reverse and failed reads complete when accepted; input takes
// a new word each cycle unless the result queue is full. Successful get and peek
// issue a RAM read and hold off input the next cycle as the read data is queued.
// A two-word result queue lets input run while a result waits at out_.
// Synchronous active-low reset clears count, front slot, reverse flag and the
// queue; the element RAM is not cleared and needs no sweep.
module reversible_indexed_deque_core #(
  parameter int CAPACITY = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rid_pkg::TDATA_W-1:0]  in_tdata,  // opcode[3:0], position[13:4], value_in[77:14]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rid_pkg::TDATA_W-1:0]  out_tdata  // value_out[63:0], ok[64], count[75:65],
                                                  // is_empty[76], is_full[77]
);

  import rid_pkg::*;

  `include "reversible_indexed_deque_core_macros.svh"

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [SW:0]   CAP_S  = (SW+1)'(CAPACITY);
  localparam logic [SW-1:0] LAST_S = SW'(CAPACITY - 1);

  logic [SW-1:0] front_r, front_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rev_r, rev_nxt;
  logic          pend_r, pend_nxt;

  logic [1:0]    oq_cnt_r, oq_cnt_nxt;
  res_t          oq0_r, oq0_nxt, oq1_r, oq1_nxt;

  logic [OPC_W-1:0] op;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic             in_fire, out_fire;

  logic             full, empty, in_range;
  logic [MW-1:0]    pos_x, cnt_x;
  logic [SW-1:0]    front_dec, front_inc;
  logic [SW-1:0]    base_idx, slot;
  logic [SW:0]      slot_sum;
  logic             use_front_dec;
  logic             mem_en, mem_we;
  logic [SW-1:0]    mem_addr;
  logic [VAL_W-1:0] mem_rdata;
  logic             ok_imm, push_imm;
  res_t             res_imm, res_rd, push_res;
  logic             push_q;
  logic [1:0]       oq_left;

  assign op  = in_tdata[OPC_W-1:0];
  assign pos = in_tdata[OPC_W+POS_W-1:OPC_W];
  assign val = in_tdata[OPC_W+POS_W+VAL_W-1:OPC_W+POS_W];

  assign in_tready = !pend_r && (oq_cnt_r != 2'd2);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (oq_cnt_r != 2'd0);
  assign out_fire  = out_tvalid && out_tready;
  assign out_tdata = {(TDATA_W - RES_W)'(0), oq0_r};

  assign full     = (cnt_r == CAP_C);
  assign empty    = (cnt_r == '0);
  assign pos_x    = MW'(pos);
  assign cnt_x    = MW'(cnt_r);
  assign in_range = (pos_x < cnt_x);

  assign front_dec = (front_r == '0) ? LAST_S : front_r - SW'(1);
  assign front_inc = (front_r == LAST_S) ? '0 : front_r + SW'(1);

  // ring slot = (front + base) mod CAPACITY, sum stays below twice capacity
  assign slot_sum = {1'b0, front_r} + {1'b0, base_idx};
  assign slot     = (slot_sum >= CAP_S) ? SW'(slot_sum - CAP_S) : slot_sum[SW-1:0];
  assign mem_addr = use_front_dec ? front_dec : slot;

  always_comb begin
    front_nxt     = front_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    pend_nxt      = 1'b0;
    base_idx      = '0;
    use_front_dec = 1'b0;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    ok_imm        = 1'b0;
    push_imm      = 1'b0;
    if (in_fire) begin
      push_imm = 1'b1;
      unique case (op)
        OP_PUSH_L, OP_PUSH_R: begin
          if (!full) begin
            ok_imm  = 1'b1;
            mem_en  = 1'b1;
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if ((op == OP_PUSH_L) != rev_r) begin
              use_front_dec = 1'b1;
              front_nxt     = front_dec;
            end else begin
              base_idx = SW'(cnt_r);
            end
          end
        end
        OP_POP_L, OP_POP_R: begin
          if (!empty) begin
            ok_imm  = 1'b1;
            cnt_nxt = cnt_r - CW'(1);
            if ((op == OP_POP_L) != rev_r) begin
              front_nxt = front_inc;
            end
          end
        end
        OP_GET, OP_SET: begin
          base_idx = rev_r ? SW'(cnt_x - MW'(1) - pos_x) : SW'(pos_x);
          if (in_range) begin
            mem_en = 1'b1;
            if (op == OP_SET) begin
              mem_we = 1'b1;
              ok_imm = 1'b1;
            end else begin
              pend_nxt = 1'b1;
              push_imm = 1'b0;
            end
          end
        end
        OP_PEEK_L, OP_PEEK_R: begin
          base_idx = ((op == OP_PEEK_L) != rev_r) ? '0 : SW'(cnt_r - CW'(1));
          if (!empty) begin
            mem_en   = 1'b1;
            pend_nxt = 1'b1;
            push_imm = 1'b0;
          end
        end
        OP_REV: begin
          rev_nxt = !rev_r;
          ok_imm  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  rid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (val),
    .rdata (mem_rdata)
  );

  always_comb begin
    res_imm.value_out = '0;
    res_imm.ok        = ok_imm;
    res_imm.count     = CNT_O_W'(cnt_nxt);
    res_imm.is_empty  = (cnt_nxt == '0);
    res_imm.is_full   = (cnt_nxt == CAP_C);
    // count does not move while a read is pending
    res_rd.value_out  = mem_rdata;
    res_rd.ok         = 1'b1;
    res_rd.count      = CNT_O_W'(cnt_r);
    res_rd.is_empty   = empty;
    res_rd.is_full    = full;
  end

  assign push_q   = push_imm || pend_r;
  assign push_res = pend_r ? res_rd : res_imm;

  // two-word result queue, head in oq0_r
  always_comb begin
    oq0_nxt = oq0_r;
    oq1_nxt = oq1_r;
    oq_left = oq_cnt_r - {1'b0, out_fire};
    if (out_fire) begin
      oq0_nxt = oq1_r;
    end
    if (push_q) begin
      if (oq_left == 2'd0) begin
        oq0_nxt = push_res;
      end else begin
        oq1_nxt = push_res;
      end
    end
    oq_cnt_nxt = oq_left + {1'b0, push_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      cnt_r    <= '0;
      rev_r    <= 1'b0;
      pend_r   <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      front_r  <= front_nxt;
      cnt_r    <= cnt_nxt;
      rev_r    <= rev_nxt;
      pend_r   <= pend_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oq0_r <= oq0_nxt;
    oq1_r <= oq1_nxt;
  end

  `RID_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CAP_C, "element count above capacity")
  `RID_ASSERT_NXT(a_read_one_cycle, pend_r, !pend_r, "read pending for more than one cycle")
  `RID_ASSERT_IMP(a_read_has_room, pend_r, oq_cnt_r != 2'd2, "read data with result queue full")
  `RID_ASSERT_NXT(a_push_count, in_fire && ok_imm && mem_we && (op == OP_PUSH_L || op == OP_PUSH_R),
                  cnt_r == $past(cnt_r) + CW'(1), "successful push did not bump count")

endmodule
